// File: sv/kpu_pkg.sv
// Package for the permutation unranking block: request and result structs,
// sequencer states, field widths and the factorial table. No dependencies.
`default_nettype none

package kpu_pkg;

	localparam int SIZE_W          = 4;
	localparam int RANK_W          = 19;
	localparam int DIGIT_W         = 4;
	localparam int MAX_SYMBOLS_DEF = 9;

	typedef struct packed {
		logic [SIZE_W-1:0] set_size;
		logic [RANK_W-1:0] rank;
	} kpu_req_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               bad_request;
	} kpu_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV
	} kpu_state_t;

	// i! for i = 0..9; larger arguments never reach a used result
	function automatic logic [RANK_W-1:0] fact_f(input logic [SIZE_W-1:0] i);
		logic [RANK_W-1:0] f;
		case (i)
			4'd0:    f = 19'd1;
			4'd1:    f = 19'd1;
			4'd2:    f = 19'd2;
			4'd3:    f = 19'd6;
			4'd4:    f = 19'd24;
			4'd5:    f = 19'd120;
			4'd6:    f = 19'd720;
			4'd7:    f = 19'd5040;
			4'd8:    f = 19'd40320;
			4'd9:    f = 19'd362880;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// File: sv/kpu_pick.sv
// Selects the idx-th free symbol (0-based) from the used flags.
// Depends on kpu_pkg for widths.
`default_nettype none

module kpu_pick
	import kpu_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  wire logic [MAX_SYMBOLS-1:0] used,
	input  wire logic [SIZE_W-1:0]      idx,
	output logic      [DIGIT_W-1:0]     sym,
	output logic      [MAX_SYMBOLS-1:0] hit
);

	always_comb begin
		logic [SIZE_W-1:0] seen;
		logic              found;
		seen  = '0;
		found = 1'b0;
		sym   = '0;
		hit   = '0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (!used[i] && !found) begin
				if (seen == idx) begin
					found  = 1'b1;
					sym    = DIGIT_W'(i + 1);
					hit[i] = 1'b1;
				end else begin
					seen = seen + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/kth_permutation_unrank_top.sv
// Top level of the k-th permutation unranking block.
// Depends on kpu_pkg and kpu_pick.
//
// Usage:
//   A request (req) carries set_size n and a 1-based rank k. It is taken at a
//   clock edge with req_valid high and req_stall low. The block answers with n
//   results on res, one digit of the k-th lexicographic permutation of 1..n
//   each, last set on the n-th. A bad request (n of 0 or above MAX_SYMBOLS,
//   k of 0 or above n!) gives one result with digit 0, last and bad_request.
//   Sequence: one request at a time. A range check comes first; then each
//   position steps the shared compare/subtract unit once per (p-1)! block
//   skipped (idx counts them) and then emits its digit. A bad result is
//   loaded straight from the range check. req_stall is high from acceptance
//   until the last result is loaded in the output register, so the next
//   request can be taken while that result still waits.
//   A result waiting under res_stall holds; the sequencer pauses before
//   loading a result until the output register is free. Reset (arst_n low)
//   returns to idle and drops res_valid; nothing else needs clearing.
`default_nettype none

module kth_permutation_unrank_top
	import kpu_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire kpu_req_t req,
	output logic          res_valid,
	input  wire logic     res_stall,
	output kpu_res_t      res
);

	localparam logic [SIZE_W-1:0] MAX_SYM_L = SIZE_W'(MAX_SYMBOLS);

	kpu_state_t             state_q, state_d;
	logic [SIZE_W-1:0]      n_q;
	logic [RANK_W-1:0]      k_q;
	logic [SIZE_W-1:0]      pos_q;
	logic [SIZE_W-1:0]      idx_q;
	logic [MAX_SYMBOLS-1:0] used_q;
	kpu_res_t               res_q;
	logic                   res_valid_q;

	logic [RANK_W-1:0]      f;
	logic                   ge;
	logic [RANK_W-1:0]      diff;
	logic                   out_free;
	logic                   bad;
	logic [DIGIT_W-1:0]     sym;
	logic [MAX_SYMBOLS-1:0] hit;

	logic                   accept;
	logic                   chk_bad_ld;
	logic                   chk_go;
	logic                   div_sub;
	logic                   div_emit;

	// shared compare/subtract against (pos-1)!
	assign f    = fact_f(pos_q - 1'b1);
	assign ge   = k_q >= f;
	assign diff = k_q - f;

	assign out_free = !res_valid_q || !res_stall;
	assign bad      = (n_q == '0) || (n_q > MAX_SYM_L) || (k_q == '0) || (k_q > fact_f(n_q));
	assign accept   = req_valid && !req_stall;

	kpu_pick #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_pick (
		.used(used_q),
		.idx (idx_q),
		.sym (sym),
		.hit (hit)
	);

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		chk_bad_ld = 1'b0;
		chk_go     = 1'b0;
		div_sub    = 1'b0;
		div_emit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (bad) begin
					if (out_free) begin
						chk_bad_ld = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					chk_go  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (ge) begin
					div_sub = 1'b1;
				end else if (out_free) begin
					div_emit = 1'b1;
					if (pos_q == SIZE_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (chk_bad_ld || div_emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (chk_go) begin
				pos_q <= n_q;
				idx_q <= '0;
			end else if (div_sub) begin
				idx_q <= idx_q + 1'b1;
			end else if (div_emit) begin
				pos_q <= pos_q - 1'b1;
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= req.set_size;
			k_q <= req.rank;
		end else if (chk_go) begin
			k_q <= k_q - 1'b1;
		end else if (div_sub) begin
			k_q <= diff;
		end
		if (chk_go) begin
			used_q <= '0;
		end else if (div_emit) begin
			used_q <= used_q | hit;
		end
		if (chk_bad_ld) begin
			res_q.digit       <= '0;
			res_q.last        <= 1'b1;
			res_q.bad_request <= 1'b1;
		end else if (div_emit) begin
			res_q.digit       <= sym;
			res_q.last        <= (pos_q == SIZE_W'(1));
			res_q.bad_request <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (pos_q != '0 && pos_q <= MAX_SYM_L))
		else $error("position out of range while dividing");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (idx_q < pos_q))
		else $error("block count reached remaining symbol count");

	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.bad_request) |-> (res.digit == '0 && res.last))
		else $error("bad result not a single zero digit");

	a_good_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.bad_request) |-> (res.digit != '0 && res.digit <= MAX_SYM_L))
		else $error("digit outside symbol range");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_emit |-> (sym != '0 && $onehot(hit)))
		else $error("no free symbol found");

endmodule

`default_nettype wire
